// ----- rtl/dccwg_pkg.sv -----
// dccwg_pkg: shared types and constants for the dcc packet waveform generator
// used by dcc_packet_waveform_generator and its port checker
// no dependencies
package dccwg_pkg;

    // packet buffer geometry
    localparam int MAX_PACKET_BYTES = 6;
    localparam int ADDR_W           = $clog2(MAX_PACKET_BYTES);
    localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);

    // fixed field widths
    localparam int OP_W          = 2;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 3;
    localparam int COUNT_W       = 3;
    localparam int REPEAT_W      = 8;
    localparam int PREAMBLE_W    = 8;
    localparam int BIT_CNT_W     = 4;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [BIT_CNT_W-1:0]  BITS_PER_BYTE   = 4'd8;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET  = 8'd14;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_BITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_STOP      = 1'b1;

    // input operations
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SUBMIT = 2'd2
    } op_t;

    // half-bit sequencer phases
    typedef enum logic [3:0] {
        PH_EDGE1      = 4'd0,
        PH_ONE2       = 4'd1,
        PH_ZERO2_MID  = 4'd2,
        PH_ZERO2      = 4'd3,
        PH_ZERO1_MID  = 4'd4,
        PH_IDLE2      = 4'd5,
        PH_IDLE1      = 4'd6,
        PH_PRE2       = 4'd7,
        PH_PRE1       = 4'd8,
        PH_START2_MID = 4'd9,
        PH_START2     = 4'd10,
        PH_START1_MID = 4'd11,
        PH_START1     = 4'd12
    } phase_t;

endpackage

// ----- rtl/dcc_packet_waveform_generator.sv -----
// dcc_packet_waveform_generator: dcc track waveform sequencer with packet buffer memory
// depends on dccwg_pkg
// checked by dccwg_checker (bound in its own file)

// One input transfer is taken every cycle while s_ready is high and yields one
// result; the op field selects a half-bit tick, a packet byte write or a
// packet submit. The packet bytes live in a small synchronous memory read
// ahead of use: a byte is fetched when the previous byte ends or a packet
// (re)starts, and its first use comes at least four ticks later, so no tick
// waits on the memory. Results pass through an output register with a skid
// stage, so one more input is taken after a result stall. Configuration
// writes take effect at the following edge and must only be made while idle.
module dcc_packet_waveform_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dccwg_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [dccwg_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dccwg_pkg::OP_W-1:0]          s_op,
    input  logic [dccwg_pkg::IDX_W-1:0]         s_byte_index,
    input  logic [dccwg_pkg::BYTE_W-1:0]        s_byte_value,
    input  logic [dccwg_pkg::COUNT_W-1:0]       s_byte_count,
    input  logic [dccwg_pkg::REPEAT_W-1:0]      s_repeat_count,
    input  logic                                s_ack_seen,
    input  logic                                s_recovery_time,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_line_level,
    output logic                                m_buffer_free,
    output logic                                m_packet_done
);
    import dccwg_pkg::*;

    localparam int CLAMP_W = LEN_W + COUNT_W;
    localparam int WIDX_W  = LEN_W + IDX_W;

    // configuration registers
    logic [PREAMBLE_W-1:0] preamble_bits_reg;
    logic                  ack_stop_enable_reg;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic                  level_reg, level_next;
    logic [BYTE_W-1:0]     shift_byte_reg, shift_byte_next;
    logic [BIT_CNT_W-1:0]  bits_left_reg, bits_left_next;
    logic [LEN_W-1:0]      send_index_reg, send_index_next;
    logic [LEN_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [PREAMBLE_W-1:0] preamble_left_reg, preamble_left_next;
    logic [REPEAT_W-1:0]   repeats_left_reg, repeats_left_next;
    logic [LEN_W-1:0]      packet_length_reg, packet_length_next;
    logic                  busy_reg, busy_next;

    // packet buffer memory and its read side
    logic [BYTE_W-1:0]     packet_mem [MAX_PACKET_BYTES];
    logic [BYTE_W-1:0]     rd_data_reg;
    logic                  load_pending_reg;
    logic                  load_zero_reg;
    logic                  rd_en;
    logic [LEN_W-1:0]      rd_addr;
    logic                  rd_in_range;
    logic                  wr_en;

    // output register and skid stage
    logic                  out_valid_reg;
    logic [2:0]            out_data_reg;
    logic                  skid_valid_reg;
    logic [2:0]            skid_data_reg;
    logic [2:0]            result;

    // decoded events
    logic                  accept;
    op_t                   op;
    logic                  is_tick;
    logic                  is_write;
    logic                  is_submit;
    logic                  bit_end;
    logic                  byte_end;
    logic                  pkt_end;
    logic                  stop;
    logic                  restart;
    logic                  toggle;
    logic [REPEAT_W-1:0]   repeats_dec;
    logic [PREAMBLE_W-1:0] preamble_dec;
    logic [CLAMP_W-1:0]    count_wide;
    logic [LEN_W-1:0]      count_clamped;
    logic [WIDX_W-1:0]     index_wide;

    assign accept    = s_valid && s_ready;
    assign op        = op_t'(s_op);
    assign is_tick   = accept && (op == OP_TICK);
    assign is_write  = accept && (op == OP_WRITE);
    assign is_submit = accept && (op == OP_SUBMIT) && !busy_reg;

    // bit, byte and packet boundaries
    assign repeats_dec  = repeats_left_reg - 1'b1;
    assign preamble_dec = preamble_left_reg - 1'b1;
    assign bit_end  = is_tick && (phase_reg == PH_ONE2 || phase_reg == PH_ZERO2_MID);
    assign byte_end = bit_end && (bits_left_reg == BIT_CNT_W'(1));
    assign pkt_end  = byte_end && (bytes_left_reg == LEN_W'(1));
    assign stop     = pkt_end && ((repeats_dec == '0) ||
                                  (ack_stop_enable_reg && s_ack_seen && !s_recovery_time));
    assign restart  = (pkt_end && !stop) ||
                      (is_tick && phase_reg == PH_IDLE2 && busy_reg);

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (is_tick) begin
            case (phase_reg)
                PH_EDGE1:      phase_next = shift_byte_reg[BYTE_W-1] ? PH_ONE2 : PH_ZERO1_MID;
                PH_ONE2,
                PH_ZERO2_MID: begin
                    if (!byte_end) begin
                        phase_next = PH_EDGE1;
                    end else if (!pkt_end) begin
                        phase_next = PH_START1;
                    end else if (stop) begin
                        phase_next = PH_IDLE1;
                    end else begin
                        phase_next = PH_PRE1;
                    end
                end
                PH_ZERO2:      phase_next = PH_ZERO2_MID;
                PH_ZERO1_MID:  phase_next = PH_ZERO2;
                PH_IDLE2:      phase_next = busy_reg ? PH_PRE1 : PH_IDLE1;
                PH_IDLE1:      phase_next = PH_IDLE2;
                PH_PRE2:       phase_next = (preamble_dec == '0) ? PH_START1 : PH_PRE1;
                PH_PRE1:       phase_next = PH_PRE2;
                PH_START2_MID: phase_next = PH_EDGE1;
                PH_START2:     phase_next = PH_START2_MID;
                PH_START1_MID: phase_next = PH_START2;
                default:       phase_next = PH_START1_MID;
            endcase
        end
    end

    // line edges on every phase except the mid-bit holds
    always_comb begin
        toggle = 1'b0;
        if (is_tick) begin
            toggle = phase_reg inside {PH_EDGE1, PH_ONE2, PH_ZERO2, PH_IDLE2, PH_IDLE1,
                                       PH_PRE2, PH_PRE1, PH_START2, PH_START1};
        end
    end

    // submit count clamp and write index check
    assign count_wide = CLAMP_W'(s_byte_count);
    assign index_wide = WIDX_W'(s_byte_index);
    always_comb begin
        if (count_wide == '0) begin
            count_clamped = LEN_W'(1);
        end else if (count_wide > CLAMP_W'(MAX_PACKET_BYTES)) begin
            count_clamped = LEN_W'(MAX_PACKET_BYTES);
        end else begin
            count_clamped = count_wide[LEN_W-1:0];
        end
    end
    assign wr_en = is_write && !busy_reg && (index_wide < WIDX_W'(MAX_PACKET_BYTES));

    // memory fetch for the next byte to send
    assign rd_en       = byte_end || restart;
    assign rd_addr     = restart ? '0 : send_index_reg + 1'b1;
    assign rd_in_range = rd_addr < LEN_W'(MAX_PACKET_BYTES);

    // datapath next values
    always_comb begin
        level_next         = level_reg ^ toggle;
        shift_byte_next    = shift_byte_reg;
        bits_left_next     = bits_left_reg;
        send_index_next    = send_index_reg;
        bytes_left_next    = bytes_left_reg;
        preamble_left_next = preamble_left_reg;
        repeats_left_next  = repeats_left_reg;
        packet_length_next = packet_length_reg;
        busy_next          = busy_reg;

        // fetched byte is loaded from the read data register once load_pending_reg is set
        if (load_pending_reg) begin
            shift_byte_next = load_zero_reg ? '0 : rd_data_reg;
        end else if (bit_end) begin
            shift_byte_next = {shift_byte_reg[BYTE_W-2:0], 1'b0};
        end

        if (bit_end) begin
            bits_left_next = byte_end ? BITS_PER_BYTE : bits_left_reg - 1'b1;
        end
        if (byte_end) begin
            send_index_next = send_index_reg + 1'b1;
            bytes_left_next = bytes_left_reg - 1'b1;
        end
        if (is_tick && phase_reg == PH_PRE2) begin
            preamble_left_next = preamble_dec;
        end
        if (pkt_end) begin
            repeats_left_next = repeats_dec;
        end

        // packet (re)start loads the counters
        if (restart) begin
            send_index_next    = '0;
            bytes_left_next    = packet_length_reg;
            preamble_left_next = preamble_bits_reg;
            bits_left_next     = BITS_PER_BYTE;
        end

        if (is_submit) begin
            packet_length_next = count_clamped;
            repeats_left_next  = s_repeat_count;
            busy_next          = 1'b1;
        end
        if (stop) begin
            busy_next = 1'b0;
        end
    end

    assign result = {level_next, !busy_next, stop};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_bits_reg   <= PREAMBLE_RESET;
            ack_stop_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_PREAMBLE_BITS: preamble_bits_reg   <= cfg_wr_data;
                CFG_ACK_STOP:      ack_stop_enable_reg <= cfg_wr_data[0];
                default:           ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE1;
            level_reg         <= 1'b0;
            shift_byte_reg    <= '0;
            bits_left_reg     <= BITS_PER_BYTE;
            send_index_reg    <= '0;
            bytes_left_reg    <= '0;
            preamble_left_reg <= '0;
            repeats_left_reg  <= '0;
            packet_length_reg <= '0;
            busy_reg          <= 1'b0;
            load_pending_reg  <= 1'b0;
            load_zero_reg     <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            level_reg         <= level_next;
            shift_byte_reg    <= shift_byte_next;
            bits_left_reg     <= bits_left_next;
            send_index_reg    <= send_index_next;
            bytes_left_reg    <= bytes_left_next;
            preamble_left_reg <= preamble_left_next;
            repeats_left_reg  <= repeats_left_next;
            packet_length_reg <= packet_length_next;
            busy_reg          <= busy_next;
            load_pending_reg  <= rd_en;
            load_zero_reg     <= !rd_in_range;
        end
    end

    // packet buffer: writes only while free, reads only while sending
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            packet_mem[s_byte_index[ADDR_W-1:0]] <= s_byte_value;
        end
        if (rd_en && rd_in_range) begin
            rd_data_reg <= packet_mem[rd_addr[ADDR_W-1:0]];
        end
    end

    // result register with skid stage
    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_valid_reg && m_ready) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!out_valid_reg || m_ready) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end else if (out_valid_reg && m_ready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_line_level  = out_data_reg[2];
    assign m_buffer_free = out_data_reg[1];
    assign m_packet_done = out_data_reg[0];

endmodule

// ----- rtl/dccwg_checker.sv -----
// dccwg_checker: port-level assertions for dcc_packet_waveform_generator
// depends on dccwg_pkg; bound to the top level at the end of this file
module dccwg_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dccwg_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [dccwg_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [dccwg_pkg::OP_W-1:0]          s_op,
    input  logic [dccwg_pkg::IDX_W-1:0]         s_byte_index,
    input  logic [dccwg_pkg::BYTE_W-1:0]        s_byte_value,
    input  logic [dccwg_pkg::COUNT_W-1:0]       s_byte_count,
    input  logic [dccwg_pkg::REPEAT_W-1:0]      s_repeat_count,
    input  logic                                s_ack_seen,
    input  logic                                s_recovery_time,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_line_level,
    input  logic                                m_buffer_free,
    input  logic                                m_packet_done
);
    import dccwg_pkg::*;

    // stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_line_level, m_buffer_free, m_packet_done}))
        else $error("result changed while stalled");

    // a finished packet always frees the buffer in the same transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_done |-> m_buffer_free)
        else $error("packet done without buffer free");

    // input only backs up when a result is already held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    // reset empties both result stages
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result stages not empty after reset");

endmodule

bind dcc_packet_waveform_generator dccwg_checker u_dccwg_checker (.*);

// ----- tb/sv/dcc_packet_waveform_generator_tb.sv -----
// dcc_packet_waveform_generator_tb: self-checking testbench for the dcc track waveform generator
// drives ticks, packet byte writes and submits, predicts every result transfer and compares them
// depends on dccwg_pkg and dcc_packet_waveform_generator
`timescale 1ns / 1ps

module dcc_packet_waveform_generator_tb;
    import dccwg_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_GAP         = 18;
    localparam int TOTAL_ITEMS     = 1950;
    localparam int RANDOM_PHASES   = 5;
    localparam int MAX_REPORTS     = 40;

    // op code the block leaves undefined
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic level;
        logic free;
        logic done;
    } line_result_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic [OP_W-1:0] s_op;
    logic [IDX_W-1:0] s_byte_index;
    logic [BYTE_W-1:0] s_byte_value;
    logic [COUNT_W-1:0] s_byte_count;
    logic [REPEAT_W-1:0] s_repeat_count;
    logic s_ack_seen;
    logic s_recovery_time;
    logic m_valid;
    logic m_ready;
    logic m_line_level;
    logic m_buffer_free;
    logic m_packet_done;

    // predicted generator state and configuration
    phase_t gen_phase;
    logic gen_level;
    logic [BYTE_W-1:0] gen_shift;
    logic [BIT_CNT_W-1:0] gen_bits_left;
    logic [IDX_W-1:0] gen_send_idx;
    logic [COUNT_W-1:0] gen_bytes_left;
    logic [PREAMBLE_W-1:0] gen_preamble_left;
    logic [REPEAT_W-1:0] gen_repeats_left;
    logic [COUNT_W-1:0] gen_length;
    logic [BYTE_W-1:0] gen_store [MAX_PACKET_BYTES];
    logic gen_busy;
    logic [PREAMBLE_W-1:0] gen_cfg_preamble;
    logic gen_cfg_ack_stop;

    line_result_t line_expect_q[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int effective_items = 0;
    int packets_done = 0;
    int config_writes = 0;
    int stuck_cycles = 0;
    int gap_run_left = 0;
    logic gaps_on = 1'b1;
    logic sender_burst = 1'b0;
    logic hold_off_request = 1'b0;

    dcc_packet_waveform_generator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_byte_index    (s_byte_index),
        .s_byte_value    (s_byte_value),
        .s_byte_count    (s_byte_count),
        .s_repeat_count  (s_repeat_count),
        .s_ack_seen      (s_ack_seen),
        .s_recovery_time (s_recovery_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_level    (m_line_level),
        .m_buffer_free   (m_buffer_free),
        .m_packet_done   (m_packet_done)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // waveform predictor
    // ------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] fetch_byte(input logic [IDX_W-1:0] i);
        if (i < MAX_PACKET_BYTES)
            return gen_store[i];
        return '0;
    endfunction

    // preamble restarts, first byte preloaded
    function automatic void restart_packet();
        gen_phase = PH_PRE1;
        gen_send_idx = '0;
        gen_shift = fetch_byte('0);
        gen_preamble_left = gen_cfg_preamble;
        gen_bytes_left = gen_length;
        gen_bits_left = BITS_PER_BYTE;
    endfunction

    function automatic void reset_generator_model();
        gen_phase = PH_IDLE1;
        gen_level = 1'b0;
        gen_shift = '0;
        gen_bits_left = BITS_PER_BYTE;
        gen_send_idx = '0;
        gen_bytes_left = '0;
        gen_preamble_left = '0;
        gen_repeats_left = '0;
        gen_length = '0;
        gen_busy = 1'b0;
        gen_cfg_preamble = PREAMBLE_RESET;
        gen_cfg_ack_stop = 1'b0;
        for (int i = 0; i < MAX_PACKET_BYTES; i++)
            gen_store[i] = '0;
    endfunction

    // one half-bit period; returns 1 when the last repeat ends or an ack stops the packet
    function automatic logic half_bit_tick(input logic ack, input logic rec);
        logic finished;
        finished = 1'b0;
        case (gen_phase)
            PH_EDGE1: begin
                gen_level = ~gen_level;
                if (gen_shift[BYTE_W-1])
                    gen_phase = PH_ONE2;
                else
                    gen_phase = PH_ZERO1_MID;
            end
            PH_ONE2, PH_ZERO2_MID: begin
                if (gen_phase == PH_ONE2)
                    gen_level = ~gen_level;
                gen_phase = PH_EDGE1;
                gen_shift = gen_shift << 1;
                gen_bits_left = gen_bits_left - 1'b1;
                if (gen_bits_left == 0) begin
                    // byte finished, move on to the next one
                    gen_send_idx = gen_send_idx + 1'b1;
                    gen_shift = fetch_byte(gen_send_idx);
                    gen_bits_left = BITS_PER_BYTE;
                    gen_bytes_left = gen_bytes_left - 1'b1;
                    if (gen_bytes_left != 0) begin
                        gen_phase = PH_START1;
                    end else begin
                        gen_repeats_left = gen_repeats_left - 1'b1;
                        if (gen_repeats_left == 0 || (gen_cfg_ack_stop && ack && !rec)) begin
                            gen_phase = PH_IDLE1;
                            gen_busy = 1'b0;
                            finished = 1'b1;
                        end else begin
                            restart_packet();
                        end
                    end
                end
            end
            PH_ZERO2: begin
                gen_level = ~gen_level;
                gen_phase = PH_ZERO2_MID;
            end
            PH_ZERO1_MID: gen_phase = PH_ZERO2;
            PH_IDLE2: begin
                gen_level = ~gen_level;
                gen_phase = PH_IDLE1;
                if (gen_busy)
                    restart_packet();
            end
            PH_IDLE1: begin
                gen_level = ~gen_level;
                gen_phase = PH_IDLE2;
            end
            PH_PRE2: begin
                gen_level = ~gen_level;
                gen_preamble_left = gen_preamble_left - 1'b1;
                if (gen_preamble_left == 0)
                    gen_phase = PH_START1;
                else
                    gen_phase = PH_PRE1;
            end
            PH_PRE1: begin
                gen_level = ~gen_level;
                gen_phase = PH_PRE2;
            end
            PH_START2_MID: gen_phase = PH_EDGE1;
            PH_START2: begin
                gen_level = ~gen_level;
                gen_phase = PH_START2_MID;
            end
            PH_START1_MID: gen_phase = PH_START2;
            default: begin
                gen_level = ~gen_level;
                gen_phase = PH_START1_MID;
            end
        endcase
        return finished;
    endfunction

    function automatic line_result_t predict_line(
        input logic [OP_W-1:0] op,
        input logic [IDX_W-1:0] idx,
        input logic [BYTE_W-1:0] val,
        input logic [COUNT_W-1:0] cnt,
        input logic [REPEAT_W-1:0] rep,
        input logic ack,
        input logic rec
    );
        line_result_t r;
        logic [COUNT_W-1:0] n;
        r.done = 1'b0;
        case (op)
            OP_TICK: begin
                r.done = half_bit_tick(ack, rec);
                effective_items++;
                if (r.done)
                    packets_done++;
            end
            OP_WRITE: begin
                if (!gen_busy && idx < MAX_PACKET_BYTES) begin
                    gen_store[idx] = val;
                    effective_items++;
                end
            end
            OP_SUBMIT: begin
                if (!gen_busy) begin
                    // out of range counts are clamped into 1..MAX_PACKET_BYTES
                    n = cnt;
                    if (n == 0)
                        n = 1;
                    if (n > MAX_PACKET_BYTES)
                        n = COUNT_W'(MAX_PACKET_BYTES);
                    gen_length = n;
                    gen_repeats_left = rep;
                    gen_busy = 1'b1;
                    effective_items++;
                end
            end
            default: begin
            end
        endcase
        r.level = gen_level;
        r.free = !gen_busy;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    task automatic send_item(
        input logic [OP_W-1:0] op,
        input logic [IDX_W-1:0] idx,
        input logic [BYTE_W-1:0] val,
        input logic [COUNT_W-1:0] cnt,
        input logic [REPEAT_W-1:0] rep,
        input logic ack,
        input logic rec
    );
        int gap;
        // stretches with and without gaps
        if (gap_run_left == 0) begin
            gap_run_left = $urandom_range(1, 48);
            gaps_on = ($urandom_range(0, 3) != 0);
        end
        gap_run_left--;
        gap = (gaps_on && !sender_burst) ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_byte_index <= idx;
        s_byte_value <= val;
        s_byte_count <= cnt;
        s_repeat_count <= rep;
        s_ack_seen <= ack;
        s_recovery_time <= rec;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
        line_expect_q.push_back(predict_line(op, idx, val, cnt, rep, ack, rec));
    endtask

    task automatic send_tick(input logic ack, input logic rec);
        send_item(OP_TICK, IDX_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom),
                  REPEAT_W'($urandom), ack, rec);
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        send_item(OP_WRITE, idx, val, COUNT_W'($urandom), REPEAT_W'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    task automatic send_submit(input logic [COUNT_W-1:0] cnt, input logic [REPEAT_W-1:0] rep);
        send_item(OP_SUBMIT, IDX_W'($urandom), BYTE_W'($urandom), cnt, rep,
                  1'($urandom), 1'($urandom));
    endtask

    // ticks until the packet has gone out, optionally mixed with ignored items
    task automatic tick_until_free(input logic noisy);
        while (gen_busy) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(OP_W'($urandom_range(1, 3)), IDX_W'($urandom), BYTE_W'($urandom),
                          COUNT_W'($urandom), REPEAT_W'($urandom), 1'($urandom),
                          1'($urandom));
            else
                send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end
    endtask

    // sender pause until every result transfer is back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (line_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_PREAMBLE_BITS)
            gen_cfg_preamble = data;
        else
            gen_cfg_ack_stop = data[0];
        config_writes++;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off on request, checking
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string field, input logic want_bit,
                                            input logic got_bit);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $error("%s: expected %0b, got %0b", field, want_bit, got_bit);
    endfunction

    initial begin : result_checker
        line_result_t want;
        line_result_t got;
        logic took;
        int stall_left;
        int run_left;
        logic stalls_on;
        m_ready = 1'b0;
        stall_left = 0;
        run_left = 0;
        stalls_on = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            took = m_valid && m_ready;
            got = '{m_line_level, m_buffer_free, m_packet_done};
            @(negedge aclk);
            if (took) begin
                if (line_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $error("result transfer with no prediction pending");
                end else begin
                    want = line_expect_q.pop_front();
                    if (got.level !== want.level)
                        report_mismatch("line_level", want.level, got.level);
                    if (got.free !== want.free)
                        report_mismatch("buffer_free", want.free, got.free);
                    if (got.done !== want.done)
                        report_mismatch("packet_done", want.done, got.done);
                end
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 48);
                    stalls_on = ($urandom_range(0, 3) != 0);
                end
                run_left--;
                stall_left = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_off_request) begin
                stall_left = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            m_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results still pending",
                         stuck_cycles, line_expect_q.size());
                $display("dcc_packet_waveform_generator_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fill every buffer entry, out of range indexes, unused op, idle ones
    task automatic test_idle_and_buffer();
        send_write(3'd0, 8'h00);
        send_write(3'd1, 8'hFF);
        send_write(3'd2, 8'h80);
        send_write(3'd3, 8'h7F);
        send_write(3'd4, 8'h01);
        send_write(3'd5, 8'hA5);
        send_write(3'd6, 8'h5A);
        send_write(3'd7, 8'hC3);
        send_item(OP_UNUSED, 3'd7, 8'hFF, 3'd7, 8'hFF, 1'b1, 1'b1);
        repeat (6) send_tick(1'b0, 1'b0);
    endtask

    // byte count of zero, writes and submits ignored while busy
    task automatic test_single_packet();
        send_submit(3'd0, 8'd1);
        send_write(3'd0, 8'hFF);
        send_submit(3'd3, 8'd5);
        tick_until_free(1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
    endtask

    // shortest preamble, count clamped to the buffer size, ack without ack stop
    task automatic test_longest_packet();
        write_register(CFG_PREAMBLE_BITS, 8'd1);
        send_submit(3'd7, 8'd2);
        while (gen_busy)
            send_tick(1'b1, 1'b0);
    endtask

    // repeat count of zero, ack held back by recovery time, then early stop
    task automatic test_ack_stop();
        write_register(CFG_ACK_STOP, {7'($urandom), 1'b1});
        send_submit(3'd1, 8'd0);
        while (gen_busy)
            send_tick(1'b1, gen_repeats_left == 8'd0 || gen_repeats_left == 8'hFF);
        write_register(CFG_ACK_STOP, {7'($urandom), 1'b0});
    endtask

    // longest preamble and the wrapped zero setting
    task automatic test_preamble_extremes();
        write_register(CFG_PREAMBLE_BITS, 8'd255);
        send_submit(3'd1, 8'd1);
        tick_until_free(1'b0);
        write_register(CFG_PREAMBLE_BITS, 8'd0);
        send_submit(3'd2, 8'd1);
        tick_until_free(1'b0);
        write_register(CFG_PREAMBLE_BITS, PREAMBLE_RESET);
    endtask

    // result side holds off while ticks keep coming, then the sender waits
    task automatic test_backpressure();
        wait_results_drained();
        hold_off_request = 1'b1;
        sender_burst = 1'b1;
        repeat (40) send_tick(1'($urandom), 1'($urandom));
        sender_burst = 1'b0;
        wait_results_drained();
    endtask

    // well-formed packets with random content, plus noise and broken sequences
    task automatic random_packet_sequence();
        int n_writes;
        logic [COUNT_W-1:0] cnt;
        logic [REPEAT_W-1:0] rep;
        n_writes = $urandom_range(0, 8);
        repeat (n_writes) send_write(IDX_W'($urandom_range(0, 7)), BYTE_W'($urandom));
        if ($urandom_range(0, 7) == 0)
            send_item(OP_UNUSED, IDX_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom),
                      REPEAT_W'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) send_tick(1'($urandom), 1'($urandom));
        end else begin
            cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 7))
                                               : COUNT_W'($urandom_range(1, 2));
            if (gen_cfg_ack_stop)
                rep = REPEAT_W'($urandom_range(0, 255));
            else
                rep = ($urandom_range(0, 5) == 0) ? REPEAT_W'($urandom_range(2, 3)) : 8'd1;
            send_submit(cnt, rep);
            tick_until_free(1'b1);
        end
        repeat ($urandom_range(0, 5)) send_tick(1'($urandom), 1'($urandom));
    endtask

    // remaining item budget is split evenly over the phases
    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_register(CFG_PREAMBLE_BITS, 8'd1);
                    write_register(CFG_ACK_STOP, 8'd0);
                end
                1: begin
                    write_register(CFG_PREAMBLE_BITS, 8'd2);
                    write_register(CFG_ACK_STOP, 8'd1);
                end
                2: begin
                    write_register(CFG_PREAMBLE_BITS, PREAMBLE_W'($urandom_range(1, 4)));
                    write_register(CFG_ACK_STOP, 8'd0);
                end
                3: begin
                    write_register(CFG_PREAMBLE_BITS, 8'd3);
                    write_register(CFG_ACK_STOP, 8'd1);
                end
                default: begin
                    write_register(CFG_PREAMBLE_BITS, PREAMBLE_W'($urandom_range(1, 6)));
                    write_register(CFG_ACK_STOP, CFG_DATA_W'($urandom));
                end
            endcase
            target = items_sent + (TOTAL_ITEMS - items_sent) / (RANDOM_PHASES - p);
            do
                random_packet_sequence();
            while (items_sent < target);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = CFG_PREAMBLE_BITS;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_op = OP_TICK;
        s_byte_index = '0;
        s_byte_value = '0;
        s_byte_count = '0;
        s_repeat_count = '0;
        s_ack_seen = 1'b0;
        s_recovery_time = 1'b0;
        reset_generator_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_buffer();
        test_single_packet();
        test_longest_packet();
        test_ack_stop();
        test_preamble_extremes();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();

        $display("covered %0d transfers (%0d not ignored), %0d packets sent to completion",
                 items_sent, effective_items, packets_done);
        $display("%0d register writes, preamble and ack stop settings incl. extremes",
                 config_writes);
        if (mismatch_count == 0)
            $display("dcc_packet_waveform_generator_tb: PASS");
        else
            $display("dcc_packet_waveform_generator_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dccwg_pkg.sv
rtl/dcc_packet_waveform_generator.sv
rtl/dccwg_checker.sv
tb/sv/dcc_packet_waveform_generator_tb.sv
